// ----- hdl/kfsi_pkg.sv -----
// Shared constants and types for the keyframe seek index.
`timescale 1ns / 1ps

package kfsi_pkg;

	localparam int DEF_TABLE_DEPTH = 4096;
	localparam int DEF_TIME_BITS   = 40;
	localparam int GOP_BITS        = 32;

	localparam logic [GOP_BITS-1:0] RESET_GAP = 32'd2000;

	// configuration register indexes
	localparam logic CFG_DURATION = 1'b0;
	localparam logic CFG_FALLBACK = 1'b1;

	// input item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// remainder unit response
	typedef struct packed {
		logic                done;
		logic [GOP_BITS-1:0] rem;
	} div_rsp_t;

endpackage

// ----- hdl/keyframe_seek_index.sv -----
// Top level of the keyframe seek index: sorted table, gap median and search sequencer.
`timescale 1ns / 1ps
// A load runs a binary search over the table and then moves the later entries up by one;
// an exact query runs a binary search; an estimated query waits on the remainder unit.
// Sealing runs a gap pass over the table and then a bitwise median select of the gaps,
// both paced by the single read port of each table memory.
// One item at a time: the next item is taken once the result is registered.
// Reset clears control state only; the table memories are not cleared.

module keyframe_seek_index #(
	parameter int TABLE_DEPTH = kfsi_pkg::DEF_TABLE_DEPTH,
	parameter int TIME_BITS   = kfsi_pkg::DEF_TIME_BITS,
	localparam int CW  = $clog2(TABLE_DEPTH + 1),
	localparam int GW  = (TIME_BITS > kfsi_pkg::GOP_BITS) ? TIME_BITS : kfsi_pkg::GOP_BITS,
	localparam int S_W = ((TIME_BITS + 1 + 7) / 8) * 8,
	localparam int M_RAW = 3 * TIME_BITS + 3 + CW,
	localparam int M_W = ((M_RAW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [S_W-1:0] s_tdata,   // time_ms (signed)
	input  logic           s_tuser,   // kind
	input  logic           s_tlast,   // last_entry
	output logic           m_tvalid,
	input  logic           m_tready,
	// floor_ms, next_ms, next_valid, typical_gap_ms, entry_count, status
	output logic [M_W-1:0] m_tdata,
	output logic           m_tuser,   // exact_mode
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [GW-1:0]  cfg_data
);

	localparam int T  = TIME_BITS;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int BW = $clog2(TIME_BITS);

	typedef enum logic [17:0] {
		ST_IDLE     = 18'b000000000000000001,
		ST_LD_SRCH  = 18'b000000000000000010,
		ST_LD_CMP   = 18'b000000000000000100,
		ST_LD_DUP   = 18'b000000000000001000,
		ST_LD_SHIFT = 18'b000000000000010000,
		ST_LD_MOVE  = 18'b000000000000100000,
		ST_LD_END   = 18'b000000000001000000,
		ST_G_READ   = 18'b000000000010000000,
		ST_G_DIFF   = 18'b000000000100000000,
		ST_M_READ   = 18'b000000001000000000,
		ST_M_COUNT  = 18'b000000010000000000,
		ST_Q_SRCH   = 18'b000000100000000000,
		ST_Q_CMP    = 18'b000001000000000000,
		ST_Q_FLOOR  = 18'b000010000000000000,
		ST_Q_NEXT   = 18'b000100000000000000,
		ST_Q_DIV    = 18'b001000000000000000,
		ST_Q_GRID   = 18'b010000000000000000,
		ST_EMIT     = 18'b100000000000000000
	} state_t;

	// configuration registers
	logic [T-1:0]                  dur_q;
	logic [kfsi_pkg::GOP_BITS-1:0] gop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= '0;
			gop_q <= kfsi_pkg::RESET_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				kfsi_pkg::CFG_DURATION: dur_q <= cfg_data[T-1:0];
				kfsi_pkg::CFG_FALLBACK: gop_q <= cfg_data[kfsi_pkg::GOP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// grid spacing: a zero fallback gap counts as one
	logic [kfsi_pkg::GOP_BITS-1:0] span;
	logic [GW-1:0]                 span_g;
	logic [T-1:0]                  span_t;

	assign span   = (gop_q == '0) ? kfsi_pkg::GOP_BITS'(1) : gop_q;
	assign span_g = GW'(span);
	assign span_t = span_g[T-1:0];

	// sequencer state
	state_t        state_q, state_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, j_q, j_d, cnt_q, cnt_d;
	logic [CW-1:0] k_q, k_d, c_q, c_d;
	logic [T-1:0]  t_q, t_d, prev_q, prev_d, cand_q, cand_d, median_q, median_d;
	logic [T-1:0]  floor_q, floor_d;
	logic [T:0]    next_q, next_d;
	logic          nv_q, nv_d, status_q, status_d, last_q, last_d;
	logic          in_use_q, in_use_d, open_q, open_d;
	logic [BW-1:0] b_q, b_d;

	// sorted timestamp table
	logic [T-1:0]  tmem [TABLE_DEPTH];
	logic [AW-1:0] t_raddr, t_waddr;
	logic          t_we;
	logic [T-1:0]  t_wdata, t_rdata_q;

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_waddr] <= t_wdata;
		end
		t_rdata_q <= tmem[t_raddr];
	end

	// gap scratch table
	logic [T-1:0]  gmem [TABLE_DEPTH];
	logic [AW-1:0] g_raddr, g_waddr;
	logic          g_we;
	logic [T-1:0]  g_wdata, g_rdata_q;

	always_ff @(posedge clk) begin
		if (g_we) begin
			gmem[g_waddr] <= g_wdata;
		end
		g_rdata_q <= gmem[g_raddr];
	end

	// remainder unit for the estimated grid
	logic               div_start;
	kfsi_pkg::div_rsp_t div_rsp;
	logic [T-1:0]       in_time;

	kfsi_rem_div #(
		.N_BITS(T)
	) u_rem_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(in_time),
		.divisor (span),
		.rsp     (div_rsp)
	);

	// clamp a negative position or timestamp to zero
	logic in_neg;
	assign in_neg  = s_tdata[T];
	assign in_time = in_neg ? '0 : s_tdata[T-1:0];

	logic acc;
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	// helpers for the sequencer
	logic [CW:0]   mid_w;
	logic [CW-1:0] mid;
	logic [CW-1:0] lo_m1, j_m1, cnt_m1, cnt_m2;
	logic [T-1:0]  bit_sel, hi_mask, cand_set;
	logic          hit;
	logic [CW-1:0] c_new;
	logic [GW-1:0] rem_g;
	logic [GW:0]   grid_next;
	logic          out_free;

	always_comb begin
		mid_w    = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
		mid      = mid_w[CW-1:0];
		lo_m1    = lo_q - CW'(1);
		j_m1     = j_q - CW'(1);
		cnt_m1   = cnt_q - CW'(1);
		cnt_m2   = cnt_q - CW'(2);
		bit_sel  = {{(T-1){1'b0}}, 1'b1} << b_q;
		hi_mask  = ~(bit_sel - T'(1));
		hit      = ((g_rdata_q ^ cand_q) & hi_mask) == '0;
		c_new    = c_q + CW'(hit);
		cand_set = (k_q < c_new) ? cand_q : (cand_q | bit_sel);
		rem_g    = GW'(div_rsp.rem);
		grid_next = {1'b0, GW'(floor_q)} + {1'b0, span_g};
	end

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		j_d      = j_q;
		cnt_d    = cnt_q;
		k_d      = k_q;
		c_d      = c_q;
		t_d      = t_q;
		prev_d   = prev_q;
		cand_d   = cand_q;
		median_d = median_q;
		floor_d  = floor_q;
		next_d   = next_q;
		nv_d     = nv_q;
		status_d = status_q;
		last_d   = last_q;
		in_use_d = in_use_q;
		open_d   = open_q;
		b_d      = b_q;
		t_raddr  = mid[AW-1:0];
		t_we     = 1'b0;
		t_waddr  = j_q[AW-1:0];
		t_wdata  = t_q;
		g_raddr  = j_q[AW-1:0];
		g_we     = 1'b0;
		g_waddr  = j_m1[AW-1:0];
		g_wdata  = t_rdata_q - prev_q;
		div_start = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					t_d      = in_time;
					last_d   = s_tlast;
					floor_d  = '0;
					next_d   = '0;
					nv_d     = 1'b0;
					status_d = 1'b0;
					lo_d     = '0;
					if (s_tuser == kfsi_pkg::KIND_LOAD) begin
						hi_d = open_q ? cnt_q : '0;
						if (!open_q) begin
							cnt_d    = '0;
							in_use_d = 1'b0;
							open_d   = 1'b1;
						end
						state_d = in_neg ? ST_LD_END : ST_LD_SRCH;
					end else if (in_use_q && cnt_q != '0) begin
						hi_d    = cnt_q;
						state_d = ST_Q_SRCH;
					end else begin
						div_start = 1'b1;
						state_d   = ST_Q_DIV;
					end
				end
			end
			ST_LD_SRCH: begin
				if (lo_q < hi_q) begin
					t_raddr = mid[AW-1:0];
					state_d = ST_LD_CMP;
				end else if (lo_q < cnt_q) begin
					t_raddr = lo_q[AW-1:0];
					state_d = ST_LD_DUP;
				end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
					status_d = 1'b1;
					state_d  = ST_LD_END;
				end else begin
					j_d     = cnt_q;
					state_d = ST_LD_SHIFT;
				end
			end
			ST_LD_CMP: begin
				if (t_rdata_q < t_q) begin
					lo_d = mid + CW'(1);
				end else begin
					hi_d = mid;
				end
				state_d = ST_LD_SRCH;
			end
			ST_LD_DUP: begin
				if (t_rdata_q == t_q) begin
					state_d = ST_LD_END;
				end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
					status_d = 1'b1;
					state_d  = ST_LD_END;
				end else begin
					j_d     = cnt_q;
					state_d = ST_LD_SHIFT;
				end
			end
			ST_LD_SHIFT: begin
				if (j_q > lo_q) begin
					t_raddr = j_m1[AW-1:0];
					state_d = ST_LD_MOVE;
				end else begin
					t_we    = 1'b1;
					t_waddr = lo_q[AW-1:0];
					t_wdata = t_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = ST_LD_END;
				end
			end
			ST_LD_MOVE: begin
				t_we    = 1'b1;
				t_waddr = j_q[AW-1:0];
				t_wdata = t_rdata_q;
				j_d     = j_m1;
				state_d = ST_LD_SHIFT;
			end
			ST_LD_END: begin
				state_d = ST_EMIT;
				if (last_q) begin
					open_d = 1'b0;
					if (cnt_q == '0) begin
						in_use_d = 1'b0;
						median_d = span_t;
					end else begin
						in_use_d = 1'b1;
						if (cnt_q == CW'(1)) begin
							median_d = span_t;
						end else begin
							j_d     = '0;
							state_d = ST_G_READ;
						end
					end
				end
			end
			ST_G_READ: begin
				t_raddr = j_q[AW-1:0];
				state_d = ST_G_DIFF;
			end
			ST_G_DIFF: begin
				g_we   = (j_q != '0);
				prev_d = t_rdata_q;
				if (j_q == cnt_m1) begin
					j_d     = '0;
					k_d     = cnt_m1 >> 1;
					c_d     = '0;
					cand_d  = '0;
					b_d     = BW'(T - 1);
					state_d = ST_M_READ;
				end else begin
					j_d     = j_q + CW'(1);
					state_d = ST_G_READ;
				end
			end
			ST_M_READ: begin
				g_raddr = j_q[AW-1:0];
				state_d = ST_M_COUNT;
			end
			ST_M_COUNT: begin
				if (j_q == cnt_m2) begin
					// one bit of the median settled: keep the lower half or step over it
					cand_d = cand_set;
					if (k_q >= c_new) begin
						k_d = k_q - c_new;
					end
					j_d = '0;
					c_d = '0;
					if (b_q == '0) begin
						median_d = (cand_set == '0) ? T'(1) : cand_set;
						state_d  = ST_EMIT;
					end else begin
						b_d     = b_q - BW'(1);
						state_d = ST_M_READ;
					end
				end else begin
					j_d     = j_q + CW'(1);
					c_d     = c_new;
					state_d = ST_M_READ;
				end
			end
			ST_Q_SRCH: begin
				if (lo_q < hi_q) begin
					t_raddr = mid[AW-1:0];
					state_d = ST_Q_CMP;
				end else begin
					t_raddr = (lo_q == '0) ? '0 : lo_m1[AW-1:0];
					state_d = ST_Q_FLOOR;
				end
			end
			ST_Q_CMP: begin
				if (t_rdata_q <= t_q) begin
					lo_d = mid + CW'(1);
				end else begin
					hi_d = mid;
				end
				state_d = ST_Q_SRCH;
			end
			ST_Q_FLOOR: begin
				floor_d = t_rdata_q;
				if (lo_q < cnt_q) begin
					t_raddr = lo_q[AW-1:0];
					state_d = ST_Q_NEXT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_Q_NEXT: begin
				next_d  = {1'b0, t_rdata_q};
				nv_d    = 1'b1;
				state_d = ST_EMIT;
			end
			ST_Q_DIV: begin
				if (div_rsp.done) begin
					floor_d = t_q - rem_g[T-1:0];
					state_d = ST_Q_GRID;
				end
			end
			ST_Q_GRID: begin
				if (dur_q != '0 && grid_next >= (GW + 1)'(dur_q)) begin
					next_d = '0;
					nv_d   = 1'b0;
				end else begin
					next_d = grid_next[T:0];
					nv_d   = 1'b1;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			in_use_q <= 1'b0;
			open_q   <= 1'b0;
			median_q <= T'(kfsi_pkg::RESET_GAP);
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			in_use_q <= in_use_d;
			open_q   <= open_d;
			median_q <= median_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		j_q      <= j_d;
		k_q      <= k_d;
		c_q      <= c_d;
		t_q      <= t_d;
		prev_q   <= prev_d;
		cand_q   <= cand_d;
		floor_q  <= floor_d;
		next_q   <= next_d;
		nv_q     <= nv_d;
		status_q <= status_d;
		last_q   <= last_d;
		b_q      <= b_d;
	end

	// result register: holds a finished transfer while the next item is taken
	logic           m_valid_q;
	logic [M_W-1:0] m_data_q;
	logic           m_user_q;
	logic           emit_fire;

	assign emit_fire = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_data_q <= M_W'({status_q, cnt_q, (in_use_q ? median_q : span_t),
				nv_q, next_q, floor_q});
			m_user_q <= in_use_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

// ----- hdl/kfsi_rem_div.sv -----
// Bit-serial restoring remainder unit for the estimated keyframe grid.
`timescale 1ns / 1ps

module kfsi_rem_div #(
	parameter int N_BITS = kfsi_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [N_BITS-1:0]             dividend,
	input  logic [kfsi_pkg::GOP_BITS-1:0] divisor,
	output kfsi_pkg::div_rsp_t            rsp
);

	localparam int D  = kfsi_pkg::GOP_BITS;
	localparam int SW = $clog2(N_BITS + 1);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] steps_q;
	logic [N_BITS-1:0] num_q;
	logic [D:0]    rem_q;
	logic [D-1:0]  div_q;
	logic [D:0]    trial;
	logic [D:0]    rem_nxt;

	always_comb begin
		trial   = {rem_q[D-1:0], num_q[N_BITS-1]};
		rem_nxt = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= SW'(N_BITS);
			end else if (busy_q) begin
				steps_q <= steps_q - SW'(1);
				if (steps_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[D-1:0];

endmodule

// ----- hdl/kfsi_checker.sv -----
// Port-level checks for the keyframe seek index, bound to the top level.
`timescale 1ns / 1ps

module kfsi_checker #(
	parameter int TABLE_DEPTH = kfsi_pkg::DEF_TABLE_DEPTH,
	parameter int TIME_BITS   = kfsi_pkg::DEF_TIME_BITS,
	localparam int CW  = $clog2(TABLE_DEPTH + 1),
	localparam int M_RAW = 3 * TIME_BITS + 3 + CW,
	localparam int M_W = ((M_RAW + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [M_W-1:0] m_tdata
);

	localparam int T      = TIME_BITS;
	localparam int NX_LO  = T;
	localparam int NV_BIT = 2 * T + 1;
	localparam int ST_BIT = M_RAW - 1;

	// one item in flight: input closes right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	// no successor means a zero next field
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[NV_BIT]) |-> (m_tdata[NX_LO +: T + 1] == '0))
		else $error("next field nonzero without a successor");

	// a dropped load carries no search result
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[ST_BIT]) |-> (!m_tdata[NV_BIT] && m_tdata[T-1:0] == '0))
		else $error("dropped load carries search fields");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind keyframe_seek_index kfsi_checker #(
	.TABLE_DEPTH(TABLE_DEPTH),
	.TIME_BITS  (TIME_BITS)
) u_kfsi_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
